### sv/dpba_pkg.sv
// Package for the depth pair beta angle block: widths, CORDIC constants,
// arctangent table and register map. No dependencies.
package dpba_pkg;
  localparam int DepthW = 20;
  localparam int AlphaW = 17;
  localparam int BetaW = 18;
  localparam int Steps = 30;
  localparam int ZW = 34;
  localparam int SCW = 32;
  localparam int XW = 54;
  localparam logic [AlphaW-1:0] AlphaTop = 17'd102943;
  localparam logic signed [SCW-1:0] GainQ30 = 32'sd652032874;
  localparam logic signed [SCW-1:0] OneQ30 = 32'sd1073741824;
  localparam logic [DepthW-1:0] MinDepthReset = 20'd4;
  localparam int PaddrW = 2;
  localparam logic [PaddrW-1:0] AddrMinDepth = 2'd0;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0: v = 34'sd843314856;  1: v = 34'sd497837829;
      2: v = 34'sd263043836;  3: v = 34'sd133525158;
      4: v = 34'sd67021686;   5: v = 34'sd33543515;
      6: v = 34'sd16775850;   7: v = 34'sd8388437;
      8: v = 34'sd4194282;    9: v = 34'sd2097149;
      10: v = 34'sd1048575;   11: v = 34'sd524287;
      12: v = 34'sd262143;    13: v = 34'sd131071;
      14: v = 34'sd65535;     15: v = 34'sd32767;
      16: v = 34'sd16383;     17: v = 34'sd8191;
      18: v = 34'sd4095;      19: v = 34'sd2047;
      20: v = 34'sd1023;      21: v = 34'sd511;
      22: v = 34'sd255;       23: v = 34'sd127;
      24: v = 34'sd63;        25: v = 34'sd31;
      26: v = 34'sd15;        27: v = 34'sd7;
      28: v = 34'sd3;         29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

### sv/dpba_rot_stage.sv
// One rotation-mode CORDIC step with its register, for sin and cos of alpha.
// Depends on dpba_pkg.
module dpba_rot_stage #(
  parameter int Step = 0
) (
  input  logic clk,
  input  logic en,
  input  logic signed [dpba_pkg::SCW-1:0] x_i,
  input  logic signed [dpba_pkg::SCW-1:0] y_i,
  input  logic signed [dpba_pkg::ZW-1:0] z_i,
  output logic signed [dpba_pkg::SCW-1:0] x_o,
  output logic signed [dpba_pkg::SCW-1:0] y_o,
  output logic signed [dpba_pkg::ZW-1:0] z_o
);
  import dpba_pkg::*;
  logic signed [SCW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  always_comb begin
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - (y_i >>> Step);
      y_nxt = y_i + (x_i >>> Step);
      z_nxt = z_i - atan_q30(Step);
    end else begin
      x_nxt = x_i + (y_i >>> Step);
      y_nxt = y_i - (x_i >>> Step);
      z_nxt = z_i + atan_q30(Step);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x_o <= x_nxt;
      y_o <= y_nxt;
      z_o <= z_nxt;
    end
  end
endmodule

### sv/dpba_vec_stage.sv
// One vectoring-mode CORDIC step with its register, for the beta angle.
// Depends on dpba_pkg.
module dpba_vec_stage #(
  parameter int Step = 0
) (
  input  logic clk,
  input  logic en,
  input  logic signed [dpba_pkg::XW-1:0] x_i,
  input  logic signed [dpba_pkg::XW-1:0] y_i,
  input  logic signed [dpba_pkg::ZW-1:0] z_i,
  output logic signed [dpba_pkg::XW-1:0] x_o,
  output logic signed [dpba_pkg::XW-1:0] y_o,
  output logic signed [dpba_pkg::ZW-1:0] z_o
);
  import dpba_pkg::*;
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  always_comb begin
    if (!y_i[XW-1]) begin
      x_nxt = x_i + (y_i >>> Step);
      y_nxt = y_i - (x_i >>> Step);
      z_nxt = z_i + atan_q30(Step);
    end else begin
      x_nxt = x_i - (y_i >>> Step);
      y_nxt = y_i + (x_i >>> Step);
      z_nxt = z_i - atan_q30(Step);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x_o <= x_nxt;
      y_o <= y_nxt;
      z_o <= z_nxt;
    end
  end
endmodule

### sv/depth_pair_beta_angle.sv
// Depth pair beta angle: registered pipeline from input accept to output valid.
// Throughput one word per cycle when not stalled; the CORDIC core is a 30+30 step pipeline.
// Whole pipeline stalls while the output word waits (global enable).
// Synchronous active-low reset clears valid bits and sets min_depth to 4.
// Depends on dpba_pkg, dpba_rot_stage, dpba_vec_stage.
module depth_pair_beta_angle (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [dpba_pkg::DepthW-1:0] in_current_depth,
  input  logic [dpba_pkg::DepthW-1:0] in_neighbor_depth,
  input  logic [dpba_pkg::AlphaW-1:0] in_alpha,
  output logic out_valid,
  input  logic out_ready,
  output logic [dpba_pkg::BetaW-1:0] out_beta,
  output logic out_skipped,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [dpba_pkg::PaddrW-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import dpba_pkg::*;
  // stage count: 1 input, 30 rotate, 1 clamp, 1 multiply, 1 subtract, 30 vector, 1 out
  localparam int Lat = 2 * Steps + 5;

  logic [DepthW-1:0] min_depth_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == AddrMinDepth) ? {12'd0, min_depth_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r <= MinDepthReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == AddrMinDepth) begin
      min_depth_r <= cfg_pwdata[DepthW-1:0];
    end
  end

  logic en;
  logic [Lat-1:0] v_r;
  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = v_r[Lat-1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Lat-2:0], in_valid};
    end
  end

  // side data carried along: skip flag, d1, d2
  localparam int SideW = 1 + 2 * DepthW;
  logic [SideW-1:0] side_r [Lat-1];

  // stage 0: order depths, saturate alpha
  logic [DepthW-1:0] d1_in, d2_in;
  logic [AlphaW-1:0] a_in;
  logic signed [ZW-1:0] z0_r;
  assign d1_in = (in_current_depth > in_neighbor_depth) ? in_current_depth : in_neighbor_depth;
  assign d2_in = (in_current_depth > in_neighbor_depth) ? in_neighbor_depth : in_current_depth;
  assign a_in = (in_alpha > AlphaTop) ? AlphaTop : in_alpha;
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= {in_current_depth < min_depth_r, d1_in, d2_in};
      z0_r <= {3'd0, a_in, 14'd0};
      for (int k = 1; k < Lat - 1; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  logic signed [SCW-1:0] rx [Steps+1];
  logic signed [SCW-1:0] ry [Steps+1];
  logic signed [ZW-1:0] rz [Steps+1];
  assign rx[0] = GainQ30;
  assign ry[0] = '0;
  assign rz[0] = z0_r;
  for (genvar i = 0; i < Steps; i++) begin : g_rot
    dpba_rot_stage #(.Step(i)) u_rot (
      .clk(clk), .en(en), .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]),
      .x_o(rx[i+1]), .y_o(ry[i+1]), .z_o(rz[i+1])
    );
  end

  // clamp sin and cos to [0, 1]
  logic [30:0] sin_r, cos_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= ry[Steps][SCW-1] ? '0 : (ry[Steps] > OneQ30) ? OneQ30[30:0] : ry[Steps][30:0];
      cos_r <= rx[Steps][SCW-1] ? '0 : (rx[Steps] > OneQ30) ? OneQ30[30:0] : rx[Steps][30:0];
    end
  end

  // multiply by d2
  logic [DepthW-1:0] d1_m, d2_m;
  assign d1_m = side_r[Steps+1][2*DepthW-1:DepthW];
  assign d2_m = side_r[Steps+1][DepthW-1:0];
  logic [50:0] ys_r, xc_r;
  logic [DepthW-1:0] d1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ys_r <= d2_m * sin_r;
      xc_r <= d2_m * cos_r;
      d1_r <= d1_m;
    end
  end

  logic signed [XW-1:0] vx [Steps+1];
  logic signed [XW-1:0] vy [Steps+1];
  logic signed [ZW-1:0] vz [Steps+1];
  logic signed [XW-1:0] x0_r, y0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= $signed({4'd0, d1_r, 30'd0}) - $signed({3'd0, xc_r});
      y0_r <= $signed({3'd0, ys_r});
    end
  end
  assign vx[0] = x0_r;
  assign vy[0] = y0_r;
  assign vz[0] = '0;
  for (genvar i = 0; i < Steps; i++) begin : g_vec
    dpba_vec_stage #(.Step(i)) u_vec (
      .clk(clk), .en(en), .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]),
      .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1])
    );
  end
  // x and y both zero: every step takes the y >= 0 arm and z climbs to the
  // table sum, so carry a flag and force zero at the end
  logic [Steps-1:0] zero_r;
  always_ff @(posedge clk) begin
    if (en) zero_r <= {zero_r[Steps-2:0], (x0_r == '0) && (y0_r == '0)};
  end

  logic [ZW-1:0] zr;
  logic [ZW-1:0] rnd;
  assign zr = vz[Steps][ZW-1] ? '0 : vz[Steps];
  assign rnd = zr + ZW'(8192);
  always_ff @(posedge clk) begin
    if (en) begin
      out_skipped <= side_r[Lat-2][SideW-1];
      out_beta <= (side_r[Lat-2][SideW-1] || zero_r[Steps-1]) ? '0 : rnd[14 +: BetaW];
    end
  end
endmodule

### sv/dpba_checker.sv
// Port-level checker for depth_pair_beta_angle, bound to the top level.
// Depends on dpba_pkg.
module dpba_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [dpba_pkg::BetaW-1:0] out_beta,
  input logic out_skipped
);
  import dpba_pkg::*;
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_skipped |-> out_beta == '0) else $error("skip with nonzero beta");
  a_beta_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beta <= 18'd205887) else $error("beta out of range");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("stall without pending word");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beta)) else $error("output dropped");
endmodule

bind depth_pair_beta_angle dpba_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_beta(out_beta),
  .out_skipped(out_skipped)
);
